// ===== design/speck_block_chained_hash_macros.svh =====
`ifndef SPECK_BLOCK_CHAINED_HASH_MACROS_SVH
`define SPECK_BLOCK_CHAINED_HASH_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SBCH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, checked while out of reset.
`define SBCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

// ===== design/sbch_pkg.sv =====
package sbch_pkg;

    localparam int WORD_W       = 64;
    localparam int BLOCK_W      = 2 * WORD_W;
    localparam int BLOCK_BYTES  = BLOCK_W / 8;
    localparam int CNT_W        = 5;
    localparam int CHAIN_WORDS  = 4;
    localparam int DIGEST_W     = CHAIN_WORDS * WORD_W;
    localparam int ROUND_COUNT  = 32;
    localparam int ROUND_W      = $clog2(ROUND_COUNT);

    localparam logic [7:0]        PAD_BYTE  = 8'h27;
    localparam logic [WORD_W-1:0] INIT_WORD = 64'h5656_5656_5656_5656;

    localparam logic [WORD_W-1:0] SEG_KEY [CHAIN_WORDS] = '{
        64'h5de2_8a12_5267_aed0,
        64'hb607_8c2c_7a3c_0035,
        64'he8bf_05f9_3e05_eab4,
        64'h8e0c_0b92_dacf_4044
    };

    typedef logic [ROUND_W-1:0] round_t;

    typedef struct packed {
        logic   load;
        logic   step;
        round_t rnd;
    } core_ctrl_t;

    function automatic logic [BLOCK_W-1:0] pad_block(input logic [BLOCK_W-1:0] blk,
                                                     input logic [CNT_W-1:0] cnt);
        logic [BLOCK_W-1:0] res;
        res = blk;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            if (CNT_W'(i) >= cnt) begin
                res[8*i +: 8] = PAD_BYTE;
            end
        end
        return res;
    endfunction

endpackage

// ===== design/speck_block_chained_hash.sv =====
// Chained 256-bit hash built on two Speck128/128 cores.
// Input channel s_*: one beat carries a 16-byte block, its valid-byte count
// and the restart, segment start and emit flags. A beat with a count of zero
// absorbs no block but still applies its flags.
// Output channel m_*: one beat carries the 256-bit chain value; it is sent
// only for input beats with emit set.
// A beat with a nonzero count occupies the block through every state, so the
// next beat is accepted only after it is done: the acceptance cycle loads
// both cores, a run of round cycles follows in which both cores run one round
// each in parallel, ST_MIX folds the ciphertexts into the chain and ST_OUT
// hands the digest to the output register for an emit beat. A beat with a
// zero count goes from acceptance straight to ST_OUT.
// s_tready is low whenever the block is not idle. The output register holds
// a digest until it is taken, so a stalled receiver does not delay the next
// input beat; only a second emit that finds the register still full waits for
// it to drain.
// Reset sets every chain byte to 0x56, clears the parity and empties the
// output register.
`include "speck_block_chained_hash_macros.svh"

module speck_block_chained_hash (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // block_low [63:0], block_high [127:64], byte_count [132:128], zero fill
    input  logic [135:0]                   s_tdata,
    // restart [0], segment_start [1], emit [2]
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // digest_word0 [63:0], digest_word1 [127:64], digest_word2 [191:128],
    // digest_word3 [255:192]
    output logic [sbch_pkg::DIGEST_W-1:0]  m_tdata
);
    import sbch_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_MIX, ST_OUT} state_t;

    localparam round_t LAST_ROUND = round_t'(ROUND_COUNT - 1);

    state_t            state_reg, state_next;
    round_t            round_reg, round_next;
    logic [WORD_W-1:0] chain_reg [CHAIN_WORDS];
    logic [WORD_W-1:0] chain_next [CHAIN_WORDS];
    logic [WORD_W-1:0] chain_pre [CHAIN_WORDS];
    logic              parity_reg, parity_next;
    logic              emit_reg, emit_next;
    logic              m_valid_reg, m_valid_next;
    logic [DIGEST_W-1:0] m_data_reg, m_data_next;

    logic               accept;
    logic               in_restart, in_seg, in_emit, in_absorb;
    logic [CNT_W-1:0]   in_cnt;
    logic [BLOCK_W-1:0] padded;
    core_ctrl_t         ctrl;
    logic [WORD_W-1:0]  a_lo, a_hi, b_lo, b_hi;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_restart = s_tuser[0];
    assign in_seg     = s_tuser[1];
    assign in_emit    = s_tuser[2];
    assign in_cnt     = s_tdata[BLOCK_W +: CNT_W];
    assign in_absorb  = (in_cnt != '0);
    assign padded     = pad_block(s_tdata[BLOCK_W-1:0], in_cnt);

    always_comb begin
        for (int i = 0; i < CHAIN_WORDS; i++) begin
            chain_pre[i] = in_restart ? INIT_WORD : chain_reg[i];
            if (in_seg) begin
                chain_pre[i] = chain_pre[i] ^ SEG_KEY[i];
            end
        end
    end

    sbch_core u_core_a (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .pt_lo (padded[WORD_W-1:0]),
        .pt_hi (padded[BLOCK_W-1:WORD_W]),
        .key_lo(chain_pre[0]),
        .key_hi(chain_pre[1]),
        .ct_lo (a_lo),
        .ct_hi (a_hi)
    );

    sbch_core u_core_b (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .pt_lo (padded[WORD_W-1:0]),
        .pt_hi (padded[BLOCK_W-1:WORD_W]),
        .key_lo(chain_pre[2]),
        .key_hi(chain_pre[3]),
        .ct_lo (b_lo),
        .ct_hi (b_hi)
    );

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        chain_next   = chain_reg;
        parity_next  = parity_reg;
        emit_next    = emit_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        ctrl.load    = 1'b0;
        ctrl.step    = 1'b0;
        ctrl.rnd     = round_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctrl.load   = 1'b1;
                    chain_next  = chain_pre;
                    parity_next = in_seg ? 1'b0 : parity_reg;
                    emit_next   = in_emit;
                    round_next  = '0;
                    state_next  = in_absorb ? ST_RUN : ST_OUT;
                end
            end
            ST_RUN: begin
                ctrl.step  = 1'b1;
                round_next = round_t'(round_reg + 1'b1);
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                if (parity_reg) begin
                    chain_next[0] = chain_reg[0] ^ a_lo;
                    chain_next[1] = chain_reg[1] ^ a_hi;
                    chain_next[2] = chain_reg[2] ^ b_lo;
                    chain_next[3] = chain_reg[3] ^ b_hi;
                end else begin
                    chain_next[0] = chain_reg[0] ^ b_lo;
                    chain_next[1] = chain_reg[1] ^ b_hi;
                    chain_next[2] = chain_reg[2] ^ a_lo;
                    chain_next[3] = chain_reg[3] ^ a_hi;
                end
                parity_next = ~parity_reg;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!emit_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            round_reg   <= '0;
            parity_reg  <= 1'b0;
            emit_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                chain_reg[i] <= INIT_WORD;
            end
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            parity_reg  <= parity_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
            chain_reg   <= chain_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SBCH_ASSERT_NEXT(a_absorb_starts_run, aclk, aresetn, accept && in_absorb, state_reg == ST_RUN && round_reg == '0)
    `SBCH_ASSERT_NEXT(a_run_ends_in_mix, aclk, aresetn, state_reg == ST_RUN && round_reg == LAST_ROUND, state_reg == ST_MIX)
    `SBCH_ASSERT_NEXT(a_mix_toggles_parity, aclk, aresetn, state_reg == ST_MIX, parity_reg != $past(parity_reg))
    `SBCH_ASSERT_NEXT(a_emit_loads_digest, aclk, aresetn, state_reg == ST_OUT && emit_reg && (!m_valid_reg || m_tready), m_tvalid && m_tdata[WORD_W-1:0] == $past(chain_reg[0]))

endmodule

// ===== design/sbch_round.sv =====
module sbch_round (
    input  logic [sbch_pkg::WORD_W-1:0] x_in,
    input  logic [sbch_pkg::WORD_W-1:0] y_in,
    input  logic [sbch_pkg::WORD_W-1:0] k_in,
    output logic [sbch_pkg::WORD_W-1:0] x_out,
    output logic [sbch_pkg::WORD_W-1:0] y_out
);
    import sbch_pkg::*;

    logic [WORD_W-1:0] x_rot;
    logic [WORD_W-1:0] y_rot;

    assign x_rot = {x_in[7:0], x_in[WORD_W-1:8]};
    assign y_rot = {y_in[WORD_W-4:0], y_in[WORD_W-1:WORD_W-3]};
    assign x_out = (x_rot + y_in) ^ k_in;
    assign y_out = y_rot ^ x_out;

endmodule

// ===== design/sbch_core.sv =====
module sbch_core (
    input  logic                         aclk,
    input  sbch_pkg::core_ctrl_t         ctrl,
    input  logic [sbch_pkg::WORD_W-1:0]  pt_lo,
    input  logic [sbch_pkg::WORD_W-1:0]  pt_hi,
    input  logic [sbch_pkg::WORD_W-1:0]  key_lo,
    input  logic [sbch_pkg::WORD_W-1:0]  key_hi,
    output logic [sbch_pkg::WORD_W-1:0]  ct_lo,
    output logic [sbch_pkg::WORD_W-1:0]  ct_hi
);
    import sbch_pkg::*;

    logic [WORD_W-1:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [WORD_W-1:0] khi_reg, khi_next, klo_reg, klo_next;
    logic [WORD_W-1:0] d_hi, d_lo, k_hi, k_lo, rconst;

    assign rconst = {{(WORD_W-ROUND_W){1'b0}}, ctrl.rnd};

    sbch_round u_data (
        .x_in (hi_reg),
        .y_in (lo_reg),
        .k_in (klo_reg),
        .x_out(d_hi),
        .y_out(d_lo)
    );

    sbch_round u_key (
        .x_in (khi_reg),
        .y_in (klo_reg),
        .k_in (rconst),
        .x_out(k_hi),
        .y_out(k_lo)
    );

    always_comb begin
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        khi_next = khi_reg;
        klo_next = klo_reg;
        if (ctrl.load) begin
            hi_next  = pt_hi;
            lo_next  = pt_lo;
            khi_next = key_hi;
            klo_next = key_lo;
        end else if (ctrl.step) begin
            hi_next  = d_hi;
            lo_next  = d_lo;
            khi_next = k_hi;
            klo_next = k_lo;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        khi_reg <= khi_next;
        klo_reg <= klo_next;
    end

    assign ct_lo = lo_reg;
    assign ct_hi = hi_reg;

endmodule

// ===== tb/sv/sbch_digest_scoreboard.sv =====
`timescale 1ns / 1ps

module sbch_digest_scoreboard (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // block_low [63:0], block_high [127:64], byte_count [132:128], zero fill
    input  logic [135:0]                  s_tdata,
    // restart [0], segment_start [1], emit [2]
    input  logic [2:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // digest_word0 [63:0], digest_word1 [127:64], digest_word2 [191:128],
    // digest_word3 [255:192]
    input  logic [sbch_pkg::DIGEST_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            outstanding
);
    import sbch_pkg::*;

    typedef struct packed {
        logic emit;
        logic segment_start;
        logic restart;
    } beat_flags_t;

    typedef struct packed {
        logic [2:0]        fill;
        logic [CNT_W-1:0]  byte_count;
        logic [WORD_W-1:0] block_high;
        logic [WORD_W-1:0] block_low;
    } beat_data_t;

    logic [DIGEST_W-1:0] chain_value;
    logic                block_parity;
    logic [DIGEST_W-1:0] digest_q[$];

    // State is {hi, lo}; one round of the cipher with round key rk.
    function automatic logic [BLOCK_W-1:0] speck_round(input logic [BLOCK_W-1:0] st,
                                                       input logic [WORD_W-1:0] rk);
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        hi = st[BLOCK_W-1:WORD_W];
        lo = st[WORD_W-1:0];
        hi = {hi[7:0], hi[WORD_W-1:8]};
        hi = (hi + lo) ^ rk;
        lo = {lo[WORD_W-4:0], lo[WORD_W-1:WORD_W-3]} ^ hi;
        return {hi, lo};
    endfunction

    function automatic logic [BLOCK_W-1:0] speck_encrypt(input logic [BLOCK_W-1:0] plain,
                                                         input logic [WORD_W-1:0] key_lo,
                                                         input logic [WORD_W-1:0] key_hi);
        logic [BLOCK_W-1:0] st;
        logic [BLOCK_W-1:0] ks;
        st = speck_round(plain, key_lo);
        ks = {key_hi, key_lo};
        for (int r = 0; r < ROUND_COUNT - 1; r++) begin
            ks = speck_round(ks, WORD_W'(r));
            st = speck_round(st, ks[WORD_W-1:0]);
        end
        return st;
    endfunction

    function automatic logic [BLOCK_W-1:0] padded_block(input logic [BLOCK_W-1:0] raw,
                                                        input int valid_bytes);
        logic [BLOCK_W-1:0] keep;
        keep = '0;
        for (int i = 0; i < valid_bytes; i++) begin
            keep[8*i +: 8] = 8'hff;
        end
        return (raw & keep) | ({BLOCK_BYTES{PAD_BYTE}} & ~keep);
    endfunction

    always @(posedge aclk) begin : watch
        beat_flags_t         flags;
        beat_data_t          beat;
        logic [DIGEST_W-1:0] want;
        logic [BLOCK_W-1:0]  blk;
        logic [BLOCK_W-1:0]  ct_low_key;
        logic [BLOCK_W-1:0]  ct_high_key;
        int                  valid_bytes;
        bit                  bad;
        if (!aresetn) begin
            chain_value  = {CHAIN_WORDS{INIT_WORD}};
            block_parity = 1'b0;
            digest_q.delete();
            fail_count   = 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t unexpected digest: expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = digest_q.pop_front();
                    bad  = 1'b0;
                    for (int w = 0; w < CHAIN_WORDS; w++) begin
                        if (m_tdata[w*WORD_W +: WORD_W] !== want[w*WORD_W +: WORD_W]) begin
                            $display("%0t digest_word%0d mismatch: expected %h, actual %h",
                                     $time, w, want[w*WORD_W +: WORD_W],
                                     m_tdata[w*WORD_W +: WORD_W]);
                            bad = 1'b1;
                        end
                    end
                    if (bad) begin
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                flags = beat_flags_t'(s_tuser);
                beat  = beat_data_t'(s_tdata);
                if (flags.restart) begin
                    chain_value = {CHAIN_WORDS{INIT_WORD}};
                end
                if (flags.segment_start) begin
                    for (int w = 0; w < CHAIN_WORDS; w++) begin
                        chain_value[w*WORD_W +: WORD_W] ^= SEG_KEY[w];
                    end
                    block_parity = 1'b0;
                end
                valid_bytes = (beat.byte_count > BLOCK_BYTES) ? BLOCK_BYTES
                                                              : int'(beat.byte_count);
                if (valid_bytes != 0) begin
                    blk = padded_block({beat.block_high, beat.block_low}, valid_bytes);
                    ct_low_key  = speck_encrypt(blk, chain_value[0 +: WORD_W],
                                                chain_value[WORD_W +: WORD_W]);
                    ct_high_key = speck_encrypt(blk, chain_value[2*WORD_W +: WORD_W],
                                                chain_value[3*WORD_W +: WORD_W]);
                    if (block_parity) begin
                        chain_value ^= {ct_high_key, ct_low_key};
                    end else begin
                        chain_value ^= {ct_low_key, ct_high_key};
                    end
                    block_parity = ~block_parity;
                end
                if (flags.emit) begin
                    digest_q.insert(digest_q.size(), chain_value);
                end
            end
            outstanding <= digest_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sbch_pkg::*;

    localparam int RANDOM_BEATS = 1200;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_TAIL   = 150;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [135:0]        s_tdata  = '0;
    logic [2:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DIGEST_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int beats_sent = 0;
    int beats_total;
    bit quiet_tail = 1'b0;
    bit hold_done  = 1'b0;

    always #5 aclk = ~aclk;

    speck_block_chained_hash u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sbch_digest_scoreboard u_score (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_beat(input bit restart, input bit seg_start,
                             input logic [WORD_W-1:0] blk_lo,
                             input logic [WORD_W-1:0] blk_hi,
                             input logic [CNT_W-1:0] count, input bit emit);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tdata  <= {3'b000, count, blk_hi, blk_lo};
        s_tuser  <= {emit, seg_start, restart};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        quiet_tail = (beats_sent >= beats_total - QUIET_TAIL);
    endtask

    initial begin
        forever begin
            if (aresetn && !hold_done && beats_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
        end
    end

    initial begin
        int nblk;
        bit last;
        beats_total = 20 + RANDOM_BEATS;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: reset digest, segment start with no block, count
        // extremes, saturated counts, restart keeping parity, all-zero and
        // all-one data.
        send_beat(1'b0, 1'b0, '0, '0, 5'd0, 1'b1);
        send_beat(1'b0, 1'b1, '0, '0, 5'd0, 1'b1);
        send_beat(1'b0, 1'b0, '1, '1, 5'd16, 1'b1);
        send_beat(1'b0, 1'b0, '0, '0, 5'd16, 1'b1);
        send_beat(1'b0, 1'b1, rand_word(), rand_word(), 5'd1, 1'b1);
        send_beat(1'b0, 1'b0, rand_word(), rand_word(), 5'd7, 1'b1);
        send_beat(1'b0, 1'b0, rand_word(), rand_word(), 5'd8, 1'b0);
        send_beat(1'b0, 1'b0, rand_word(), rand_word(), 5'd9, 1'b1);
        send_beat(1'b0, 1'b0, '1, '1, 5'd15, 1'b1);
        send_beat(1'b0, 1'b0, rand_word(), rand_word(), 5'd17, 1'b1);
        send_beat(1'b0, 1'b0, '1, '1, 5'd31, 1'b1);
        send_beat(1'b1, 1'b0, rand_word(), rand_word(), 5'd5, 1'b1);
        send_beat(1'b1, 1'b0, '0, '0, 5'd0, 1'b1);
        send_beat(1'b1, 1'b1, rand_word(), rand_word(), 5'd16, 1'b0);
        send_beat(1'b0, 1'b0, rand_word(), rand_word(), 5'd16, 1'b0);
        send_beat(1'b0, 1'b0, rand_word(), rand_word(), 5'd3, 1'b1);
        send_beat(1'b0, 1'b0, '0, '0, 5'd0, 1'b0);
        send_beat(1'b1, 1'b1, '0, '0, 5'd0, 1'b0);
        send_beat(1'b0, 1'b0, rand_word(), rand_word(), 5'd24, 1'b1);
        send_beat(1'b0, 1'b0, rand_word(), rand_word(), 5'd12, 1'b1);

        while (beats_sent < beats_total) begin
            if ($urandom_range(0, 3) == 0) begin
                send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_word(),
                          rand_word(), CNT_W'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
            end else begin
                nblk = $urandom_range(1, 6);
                for (int b = 0; b < nblk; b++) begin
                    last = (b == nblk - 1);
                    send_beat(b == 0 && $urandom_range(0, 3) == 0, b == 0,
                              rand_word(), rand_word(),
                              last ? CNT_W'($urandom_range(1, 16)) : CNT_W'(16),
                              last || $urandom_range(0, 7) == 0);
                end
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("speck_block_chained_hash verification clean");
        end else begin
            $display("speck_block_chained_hash verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("speck_block_chained_hash verification failed");
        $finish;
    end

endmodule
